@@ rtl/bba_pkg.sv @@
`default_nettype none
package bba_pkg;

  typedef enum logic [1:0] {
    OP_FIND      = 2'd0,
    OP_MARK_USED = 2'd1,
    OP_MARK_FREE = 2'd2,
    OP_LOAD      = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_MODIFY = 5'b01000,
    S_OUT    = 5'b10000
  } state_t;

  localparam int BYTE_W = 8;

endpackage
`default_nettype wire

@@ rtl/bitmap_block_allocator.sv @@
`default_nettype none
// channel | direction | handshake           | payload
// in      | input     | in_valid/in_ready   | operation, block_index, load_address, load_value
// out     | output    | out_valid/out_ready | found, free_block, byte_position, bit_offset,
//         |           |                     | free_count
// find scans one bitmap byte per cycle from the memory's registered read port; mark and
// load step through read, modify-write and result, and skip the write when out of range
// after reset a clearing pass writes zero to every byte, with in_ready low
// one item at a time; the next item is taken while the last result waits in the output
// register, and its result is held back until that one is taken
module bitmap_block_allocator #(
  parameter int BITMAP_BYTES = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_operation,
  input  wire logic [9:0]  in_block_index,
  input  wire logic [6:0]  in_load_address,
  input  wire logic [7:0]  in_load_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_found,
  output logic [9:0]       out_free_block,
  output logic [6:0]       out_byte_position,
  output logic [2:0]       out_bit_offset,
  output logic [10:0]      out_free_count
);

  localparam int AW    = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
  localparam int TOTAL = BITMAP_BYTES * bba_pkg::BYTE_W;
  localparam int CNT_W = $clog2(TOTAL + 1);
  localparam logic [AW-1:0] LAST = AW'(BITMAP_BYTES - 1);

  function automatic logic [3:0] zeros(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (!v[i]) begin
        n = n + 4'd1;
      end
    end
    return n;
  endfunction

  function automatic logic [2:0] first_zero(input logic [7:0] v);
    logic [2:0] b;
    b = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (!v[i]) begin
        b = 3'(i);
      end
    end
    return b;
  endfunction

  bba_pkg::state_t   state_r, state_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  bba_pkg::op_t      op_r, op_nxt;
  logic [2:0]        bit_sel_r, bit_sel_nxt;
  logic [7:0]        val_r, val_nxt;
  logic              res_found_r, res_found_nxt;
  logic [2:0]        res_bit_r, res_bit_nxt;
  logic [7:0]        rd_data_r;
  logic [7:0]        mem [BITMAP_BYTES];
  logic              we;
  logic [7:0]        wdata;
  logic              out_valid_r, out_valid_nxt;
  logic              o_found_r, o_found_nxt;
  logic [9:0]        o_block_r, o_block_nxt;
  logic [6:0]        o_byte_r, o_byte_nxt;
  logic [2:0]        o_bit_r, o_bit_nxt;
  logic [10:0]       o_count_r, o_count_nxt;

  logic [12:0]       mark_addr, load_addr, ptr_ext;
  logic [15:0]       blk_wide;
  logic [CNT_W+10:0] cnt_ext;
  logic [7:0]        mask, new_byte;
  logic              mark_ok, load_ok;

  always_comb begin
    mark_addr = {6'd0, in_block_index[9:3]};
    load_addr = {6'd0, in_load_address};
    mark_ok   = 32'(in_block_index) < 32'(TOTAL);
    load_ok   = 32'(in_load_address) < 32'(BITMAP_BYTES);
    ptr_ext   = {{(13 - AW){1'b0}}, ptr_r};
    blk_wide  = {ptr_ext, res_bit_r};
    cnt_ext   = {11'd0, cnt_r};
    mask      = 8'd1 << bit_sel_r;
    case (op_r)
      bba_pkg::OP_MARK_USED: new_byte = rd_data_r | mask;
      bba_pkg::OP_MARK_FREE: new_byte = rd_data_r & ~mask;
      bba_pkg::OP_LOAD:      new_byte = val_r;
      default:               new_byte = rd_data_r;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    cnt_nxt       = cnt_r;
    op_nxt        = op_r;
    bit_sel_nxt   = bit_sel_r;
    val_nxt       = val_r;
    res_found_nxt = res_found_r;
    res_bit_nxt   = res_bit_r;
    we            = 1'b0;
    wdata         = 8'd0;
    out_valid_nxt = out_valid_r & ~out_ready;
    o_found_nxt   = o_found_r;
    o_block_nxt   = o_block_r;
    o_byte_nxt    = o_byte_r;
    o_bit_nxt     = o_bit_r;
    o_count_nxt   = o_count_r;
    in_ready      = 1'b0;
    case (state_r)
      bba_pkg::S_CLEAR: begin
        we = 1'b1;
        if (ptr_r == LAST) begin
          ptr_nxt   = '0;
          state_nxt = bba_pkg::S_IDLE;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      bba_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt        = bba_pkg::op_t'(in_operation);
          bit_sel_nxt   = in_block_index[2:0];
          val_nxt       = in_load_value;
          res_found_nxt = 1'b0;
          res_bit_nxt   = 3'd0;
          case (bba_pkg::op_t'(in_operation))
            bba_pkg::OP_FIND: begin
              ptr_nxt   = '0;
              state_nxt = bba_pkg::S_SCAN;
            end
            bba_pkg::OP_MARK_USED, bba_pkg::OP_MARK_FREE: begin
              ptr_nxt   = mark_addr[AW-1:0];
              state_nxt = mark_ok ? bba_pkg::S_MODIFY : bba_pkg::S_OUT;
            end
            default: begin
              ptr_nxt   = load_addr[AW-1:0];
              state_nxt = load_ok ? bba_pkg::S_MODIFY : bba_pkg::S_OUT;
            end
          endcase
        end
      end
      bba_pkg::S_SCAN: begin
        if (rd_data_r != 8'hFF) begin
          res_found_nxt = 1'b1;
          res_bit_nxt   = first_zero(rd_data_r);
          state_nxt     = bba_pkg::S_OUT;
        end else if (ptr_r == LAST) begin
          state_nxt = bba_pkg::S_OUT;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      bba_pkg::S_MODIFY: begin
        we        = 1'b1;
        wdata     = new_byte;
        cnt_nxt   = cnt_r + CNT_W'(zeros(new_byte)) - CNT_W'(zeros(rd_data_r));
        state_nxt = bba_pkg::S_OUT;
      end
      bba_pkg::S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          o_found_nxt   = res_found_r;
          o_block_nxt   = res_found_r ? blk_wide[9:0] : 10'd0;
          o_byte_nxt    = res_found_r ? ptr_ext[6:0] : 7'd0;
          o_bit_nxt     = res_found_r ? res_bit_r : 3'd0;
          o_count_nxt   = cnt_ext[10:0];
          state_nxt     = bba_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bba_pkg::S_IDLE;
      end
    endcase
  end

  // bitmap memory, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[ptr_r] <= wdata;
    end
    rd_data_r <= mem[ptr_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bba_pkg::S_CLEAR;
      ptr_r       <= '0;
      cnt_r       <= CNT_W'(TOTAL);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    bit_sel_r   <= bit_sel_nxt;
    val_r       <= val_nxt;
    res_found_r <= res_found_nxt;
    res_bit_r   <= res_bit_nxt;
    o_found_r   <= o_found_nxt;
    o_block_r   <= o_block_nxt;
    o_byte_r    <= o_byte_nxt;
    o_bit_r     <= o_bit_nxt;
    o_count_r   <= o_count_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_found         = o_found_r;
  assign out_free_block    = o_block_r;
  assign out_byte_position = o_byte_r;
  assign out_bit_offset    = o_bit_r;
  assign out_free_count    = o_count_r;

endmodule
`default_nettype wire
